>>> rtl/egcd_pkg.sv
package egcd_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } egcd_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands and seed the coefficient pairs
    logic div_init;  // set up the divider for prev_r / cur_r
    logic div_step;  // one restoring step plus coefficient shift-add
    logic update;    // rotate remainder and coefficient pairs
    logic out_load;  // copy the result into the output register
  } egcd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cur_zero;  // current remainder is zero: gcd found
    logic div_last;  // divider is on its last step
  } egcd_stat_t;

endpackage

>>> rtl/egcd_if.sv
// Operand channel
interface egcd_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_value;
  logic signed [DATA_WIDTH-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

// Result channel
interface egcd_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] gcd_value;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;

  modport source (output valid, output gcd_value, output coef_a, output coef_b, input ready);
  modport sink   (input valid, input gcd_value, input coef_a, input coef_b, output ready);
endinterface

>>> rtl/egcd_ctrl.sv
module egcd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  egcd_pkg::egcd_stat_t  stat,
  output egcd_pkg::egcd_cmd_t   cmd
);

  egcd_pkg::egcd_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = egcd_pkg::ST_CHECK;
      end
      egcd_pkg::ST_CHECK: begin
        state_nxt = stat.cur_zero ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
      end
      egcd_pkg::ST_DIV: begin
        if (stat.div_last) state_nxt = egcd_pkg::ST_UPDATE;
      end
      egcd_pkg::ST_UPDATE: begin
        state_nxt = egcd_pkg::ST_CHECK;
      end
      egcd_pkg::ST_DONE: begin
        if (out_free) state_nxt = egcd_pkg::ST_IDLE;
      end
      default: state_nxt = egcd_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      egcd_pkg::ST_CHECK: begin
        cmd.div_init = !stat.cur_zero;
      end
      egcd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      egcd_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      egcd_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/egcd_dp.sv
module egcd_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  input  egcd_pkg::egcd_cmd_t   cmd,
  output egcd_pkg::egcd_stat_t  stat,
  output logic [DATA_WIDTH-1:0] out_gcd,
  output logic [DATA_WIDTH-1:0] out_coef_a,
  output logic [DATA_WIDTH-1:0] out_coef_b
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  // Euclid state: remainders r, coefficients of b (s) and of a (t)
  logic [W-1:0]  prev_r_r, cur_r_r, prev_s_r, cur_s_r, prev_t_r, cur_t_r;
  // Divider state
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r;
  logic [W-1:0]  ps_r, ps_nxt;
  logic [W-1:0]  pt_r, pt_nxt;
  logic [CW-1:0] cnt_r;
  logic          qneg_r, rneg_r;
  // Output register
  logic [W-1:0]  gcd_r, coef_a_r, coef_b_r;

  logic [W:0]    trial, diff;
  logic          qbit;
  logic [W-1:0]  nr_nxt, ns_nxt, nt_nxt;
  logic [W-1:0]  prev_mag, cur_mag;

  assign prev_mag = prev_r_r[W-1] ? ({W{1'b0}} - prev_r_r) : prev_r_r;
  assign cur_mag  = cur_r_r[W-1]  ? ({W{1'b0}} - cur_r_r)  : cur_r_r;

  // One restoring division step; |q| * cur_s and |q| * cur_t built by shift-add
  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    diff    = trial - {1'b0, dsr_r};
    qbit    = !diff[W];
    rem_nxt = qbit ? diff[W-1:0] : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], qbit};
    ps_nxt  = {ps_r[W-2:0], 1'b0} + (qbit ? cur_s_r : {W{1'b0}});
    pt_nxt  = {pt_r[W-2:0], 1'b0} + (qbit ? cur_t_r : {W{1'b0}});
  end

  // Signed remainder and new coefficients
  always_comb begin
    nr_nxt = rneg_r ? ({W{1'b0}} - rem_r) : rem_r;
    ns_nxt = qneg_r ? (prev_s_r + ps_r) : (prev_s_r - ps_r);
    nt_nxt = qneg_r ? (prev_t_r + pt_r) : (prev_t_r - pt_r);
  end

  assign stat.cur_zero = (cur_r_r == {W{1'b0}});
  assign stat.div_last = (cnt_r == {CW{1'b0}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r_r  <= in_a;
      prev_r_r <= in_b;
      cur_s_r  <= {W{1'b0}};
      prev_s_r <= {{(W-1){1'b0}}, 1'b1};
      cur_t_r  <= {{(W-1){1'b0}}, 1'b1};
      prev_t_r <= {W{1'b0}};
    end else if (cmd.div_init) begin
      rem_r  <= {W{1'b0}};
      quo_r  <= prev_mag;
      dsr_r  <= cur_mag;
      ps_r   <= {W{1'b0}};
      pt_r   <= {W{1'b0}};
      cnt_r  <= CW'(DATA_WIDTH - 1);
      qneg_r <= prev_r_r[W-1] ^ cur_r_r[W-1];
      rneg_r <= prev_r_r[W-1];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      ps_r  <= ps_nxt;
      pt_r  <= pt_nxt;
      cnt_r <= cnt_r - 1'b1;
    end else if (cmd.update) begin
      prev_r_r <= cur_r_r;
      cur_r_r  <= nr_nxt;
      prev_s_r <= cur_s_r;
      cur_s_r  <= ns_nxt;
      prev_t_r <= cur_t_r;
      cur_t_r  <= nt_nxt;
    end
  end

  // Capture the finished result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gcd_r    <= prev_r_r;
      coef_a_r <= prev_t_r;
      coef_b_r <= prev_s_r;
    end
  end

  assign out_gcd    = gcd_r;
  assign out_coef_a = coef_a_r;
  assign out_coef_b = coef_b_r;

endmodule

>>> rtl/extended_gcd_bezout.sv
// Extended Euclid (gcd with Bezout coefficients), one item at a time.
// Each of the n Euclid steps is a bit-serial restoring division,
// one quotient bit per cycle (n <= 46 at 32 bits).
// A new item is taken only once the last one is done; it is taken while that result waits.
// Reset (synchronous, active low) clears the controller and the output valid;
// no state carries from one item to the next.
module extended_gcd_bezout #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  egcd_in_if.sink   in_ch,
  egcd_out_if.source out_ch
);

  egcd_pkg::egcd_cmd_t  cmd;
  egcd_pkg::egcd_stat_t stat;
  logic [DATA_WIDTH-1:0] gcd_w, coef_a_w, coef_b_w;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  egcd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .in_a       (in_ch.a_value),
    .in_b       (in_ch.b_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_gcd    (gcd_w),
    .out_coef_a (coef_a_w),
    .out_coef_b (coef_b_w)
  );

  assign out_ch.gcd_value = gcd_w;
  assign out_ch.coef_a    = coef_a_w;
  assign out_ch.coef_b    = coef_b_w;

  // No second item is taken right after a transfer
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // A result is only stored once the current remainder reached zero
  a_load_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.cur_zero)
    else $error("result stored before gcd was found");

  // Pair rotation only follows the last divider step
  a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> ($past(cmd.div_step) && $past(stat.div_last)))
    else $error("update without a finished division");

  // The output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_ch.valid) |-> out_ch.ready)
    else $error("pending result overwritten");

endmodule
